@@ rtl/uart_serial_transmitter_defines.svh @@
// assertion macros for the serial transmitter
`ifndef UART_SERIAL_TRANSMITTER_DEFINES_SVH
`define UART_SERIAL_TRANSMITTER_DEFINES_SVH

`ifndef SYNTHESIS

// cond must hold in the same cycle as trig
`define UST_ASSERT_SAME(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// cond must hold in the cycle after trig
`define UST_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`else

`define UST_ASSERT_SAME(label, trig, cond, msg)
`define UST_ASSERT_NEXT(label, trig, cond, msg)

`endif

`endif

@@ rtl/ust_pkg.sv @@
// shared types and constants of the serial transmitter
package ust_pkg;

	// baud counter width default
	localparam int DividerWidthDef = 16;

	// depth of the queue between front and engine (power of two)
	localparam int QueueDepth = 4;

	// register map
	localparam int RegIdxW = 3;
	localparam logic [RegIdxW-1:0] REG_BIT_PERIOD    = 3'd0;
	localparam logic [RegIdxW-1:0] REG_WORD_LEN      = 3'd1;
	localparam logic [RegIdxW-1:0] REG_PARITY_ENABLE = 3'd2;
	localparam logic [RegIdxW-1:0] REG_PARITY_ODD    = 3'd3;
	localparam logic [RegIdxW-1:0] REG_STOP_COUNT    = 3'd4;

	// register reset values
	localparam logic [15:0] BitPeriodRst    = 16'd5208;
	localparam logic [3:0]  DataBitsRst     = 4'd8;
	localparam logic        ParityEnableRst = 1'b1;
	localparam logic        ParityOddRst    = 1'b0;
	localparam logic [1:0]  StopCountRst    = 2'd1;

	// data bit and stop bit limits
	localparam logic [3:0] DataBitsMin = 4'd5;
	localparam logic [3:0] DataBitsMax = 4'd8;
	localparam logic [1:0] StopMin     = 2'd1;
	localparam logic [1:0] StopMax     = 2'd2;

	typedef enum logic {
		OP_TICK,
		OP_SEND
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  data;
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_DATA,
		PH_PARITY,
		PH_STOP
	} phase_t;

	// frame format, already clamped to legal values
	typedef struct packed {
		logic [3:0] word_len;
		logic       parity_enable;
		logic       parity_odd;
		logic [1:0] stop_count;
	} frame_cfg_t;

endpackage

@@ rtl/ust_front.sv @@
// front stage: takes input beats and turns them into queue operations
module ust_front
	import ust_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	input  logic [7:0] tx_byte,
	output logic       push_valid,
	input  logic       push_ready,
	output op_t        push_op
);

	logic s1_valid_q;
	op_t  op_s1;

	// stage is free when empty or when its beat moves on this cycle
	assign in_ready   = !s1_valid_q || push_ready;
	assign push_valid = s1_valid_q;
	assign push_op    = op_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	// classify the beat: a tick or a send request
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1.kind <= command ? OP_SEND : OP_TICK;
			op_s1.data <= tx_byte;
		end
	end

endmodule

@@ rtl/ust_queue.sv @@
// short fifo between front and engine
module ust_queue
	import ust_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  op_t  push_op,
	output logic pop_valid,
	input  logic pop_ready,
	output op_t  pop_op
);

	localparam int PtrW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	op_t            entry_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push;
	logic            pop;

	assign push_ready = count_q != CntW'(QueueDepth);
	assign pop_valid  = count_q != '0;
	assign pop_op     = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

@@ rtl/ust_engine.sv @@
// back end: frame sequencer, baud counter and result register
module ust_engine
	import ust_pkg::*;
#(
	parameter int DIVIDER_WIDTH = DividerWidthDef
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     pop_valid,
	output logic                     pop_ready,
	input  op_t                      pop_op,
	input  logic [DIVIDER_WIDTH-1:0] period,
	input  frame_cfg_t               fcfg,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     tx_line,
	output logic                     busy_res,
	output logic                     rejected,
	output logic                     frame_done
);

	phase_t                    phase_q, phase_d;
	logic [DIVIDER_WIDTH-1:0]  tick_q, tick_d;
	logic [3:0]                bitpos_q, bitpos_d;
	logic [7:0]                shift_q, shift_d;
	logic                      parity_q, parity_d;
	logic                      line_q, line_d;
	logic                      done_d;
	logic                      out_valid_q;

	logic                      step;
	logic                      is_send;
	logic                      idle;
	logic                      start;
	logic                      reject;
	logic                      tick;
	logic [DIVIDER_WIDTH:0]    next_cnt;
	logic [DIVIDER_WIDTH-1:0]  period_eff;
	logic                      bit_end;
	logic [3:0]                bitpos_inc;
	logic                      data_last;
	logic                      stop_last;

	// one op per cycle unless the result register is held
	assign pop_ready = !out_valid_q || out_ready;
	assign step      = pop_valid && pop_ready;
	assign is_send   = pop_op.kind == OP_SEND;
	assign idle      = phase_q == PH_IDLE;
	assign start     = step && is_send && idle;
	assign reject    = step && is_send && !idle;
	assign tick      = step && !is_send && !idle;

	// baud counter compare, a zero period counts as one
	assign period_eff = (period == '0) ? DIVIDER_WIDTH'(1) : period;
	assign next_cnt   = {1'b0, tick_q} + 1'b1;
	assign bit_end    = tick && (next_cnt >= {1'b0, period_eff});

	// end of data and stop sections
	assign bitpos_inc = bitpos_q + 4'd1;
	assign data_last  = bitpos_inc >= fcfg.word_len;
	assign stop_last  = bitpos_inc >= {2'b00, fcfg.stop_count};

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (start) begin
			phase_d = PH_START;
		end else if (bit_end) begin
			case (phase_q)
				PH_START: begin
					phase_d = PH_DATA;
				end
				PH_DATA: begin
					if (data_last) begin
						phase_d = fcfg.parity_enable ? PH_PARITY : PH_STOP;
					end
				end
				PH_PARITY: begin
					phase_d = PH_STOP;
				end
				PH_STOP: begin
					if (stop_last) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// datapath and line level
	always_comb begin
		tick_d   = tick_q;
		bitpos_d = bitpos_q;
		shift_d  = shift_q;
		parity_d = parity_q;
		line_d   = line_q;
		done_d   = 1'b0;
		if (start) begin
			shift_d  = pop_op.data;
			tick_d   = '0;
			bitpos_d = '0;
			parity_d = 1'b0;
			line_d   = 1'b0;
		end else if (step && !is_send && idle) begin
			line_d = 1'b1;
		end else if (tick && !bit_end) begin
			tick_d = next_cnt[DIVIDER_WIDTH-1:0];
		end else if (bit_end) begin
			tick_d = '0;
			case (phase_q)
				PH_START: begin
					bitpos_d = '0;
					line_d   = shift_q[0];
					parity_d = parity_q ^ shift_q[0];
				end
				PH_DATA: begin
					bitpos_d = bitpos_inc;
					shift_d  = {1'b0, shift_q[7:1]};
					if (data_last) begin
						if (fcfg.parity_enable) begin
							line_d = parity_q ^ fcfg.parity_odd;
						end else begin
							bitpos_d = '0;
							line_d   = 1'b1;
						end
					end else begin
						line_d   = shift_q[1];
						parity_d = parity_q ^ shift_q[1];
					end
				end
				PH_PARITY: begin
					bitpos_d = '0;
					line_d   = 1'b1;
				end
				PH_STOP: begin
					bitpos_d = bitpos_inc;
					if (stop_last) begin
						bitpos_d = '0;
						line_d   = 1'b1;
						done_d   = 1'b1;
					end
				end
				default: begin
					line_d = 1'b1;
				end
			endcase
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tick_q   <= '0;
			bitpos_q <= '0;
			shift_q  <= '0;
			parity_q <= 1'b0;
			line_q   <= 1'b1;
		end else begin
			phase_q  <= phase_d;
			tick_q   <= tick_d;
			bitpos_q <= bitpos_d;
			shift_q  <= shift_d;
			parity_q <= parity_d;
			line_q   <= line_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= step;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (step) begin
			tx_line    <= line_d;
			busy_res   <= phase_d != PH_IDLE;
			rejected   <= reject;
			frame_done <= done_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/uart_serial_transmitter.sv @@
// Serial transmitter top level: register port, front stage, queue and frame engine.
// Each input beat is one clock tick of the baud counter or a request to send a byte;
// every beat gives exactly one result beat. The block takes one beat per clock cycle
// for as long as the result side keeps up: a front register, a four-entry queue and
// a result register sit in that order on the path from each beat to its result, and
// the queue absorbs short stalls of the result side before in_ready drops. A frame is
// a low start bit, 5 to 8 data bits LSB first, an optional parity bit and one or two
// stop bits, each bit_period ticks long. Registers sit at byte addresses 0 (bit_period),
// 4 (word length), 8 (parity_enable), 12 (parity_odd) and 16 (stop_count); write them
// only while no frame is running.
`include "uart_serial_transmitter_defines.svh"

module uart_serial_transmitter
	import ust_pkg::*;
#(
	parameter int DIVIDER_WIDTH = DividerWidthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  tx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        tx_line,
	output logic        busy_res,
	output logic        rejected,
	output logic        frame_done
);

	logic [15:0]              bit_period_q;
	logic [3:0]               word_len_q;
	logic                     parity_enable_q;
	logic                     parity_odd_q;
	logic [1:0]               stop_count_q;
	logic [RegIdxW-1:0]       reg_idx;
	logic                     reg_wr;
	logic [31:0]              period_wide;
	logic [DIVIDER_WIDTH-1:0] period;
	frame_cfg_t               fcfg;
	logic                     push_valid;
	logic                     push_ready;
	op_t                      push_op;
	logic                     pop_valid;
	logic                     pop_ready;
	op_t                      pop_op;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q    <= BitPeriodRst;
			word_len_q      <= DataBitsRst;
			parity_enable_q <= ParityEnableRst;
			parity_odd_q    <= ParityOddRst;
			stop_count_q    <= StopCountRst;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_BIT_PERIOD:    bit_period_q    <= pwdata[15:0];
				REG_WORD_LEN:      word_len_q      <= pwdata[3:0];
				REG_PARITY_ENABLE: parity_enable_q <= pwdata[0];
				REG_PARITY_ODD:    parity_odd_q    <= pwdata[0];
				REG_STOP_COUNT:    stop_count_q    <= pwdata[1:0];
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_BIT_PERIOD:    prdata = {16'd0, bit_period_q};
			REG_WORD_LEN:      prdata = {28'd0, word_len_q};
			REG_PARITY_ENABLE: prdata = {31'd0, parity_enable_q};
			REG_PARITY_ODD:    prdata = {31'd0, parity_odd_q};
			REG_STOP_COUNT:    prdata = {30'd0, stop_count_q};
			default:           prdata = '0;
		endcase
	end

	// divider kept to the counter width
	assign period_wide = {16'd0, bit_period_q};
	assign period      = period_wide[DIVIDER_WIDTH-1:0];

	// clamp the frame format to legal values
	always_comb begin
		fcfg.parity_enable = parity_enable_q;
		fcfg.parity_odd    = parity_odd_q;
		if (word_len_q < DataBitsMin) begin
			fcfg.word_len = DataBitsMin;
		end else if (word_len_q > DataBitsMax) begin
			fcfg.word_len = DataBitsMax;
		end else begin
			fcfg.word_len = word_len_q;
		end
		if (stop_count_q < StopMin) begin
			fcfg.stop_count = StopMin;
		end else if (stop_count_q > StopMax) begin
			fcfg.stop_count = StopMax;
		end else begin
			fcfg.stop_count = stop_count_q;
		end
	end

	ust_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.tx_byte    (tx_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op)
	);

	ust_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_op     (pop_op)
	);

	ust_engine #(
		.DIVIDER_WIDTH (DIVIDER_WIDTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_op     (pop_op),
		.period     (period),
		.fcfg       (fcfg),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.tx_line    (tx_line),
		.busy_res   (busy_res),
		.rejected   (rejected),
		.frame_done (frame_done)
	);

	// result consistency checks
	`UST_ASSERT_SAME(a_idle_line_high, out_valid && !busy_res, tx_line, "idle result with low line")
	`UST_ASSERT_SAME(a_reject_busy, out_valid && rejected, busy_res && !frame_done, "reject while idle")
	`UST_ASSERT_SAME(a_done_idle, out_valid && frame_done, !busy_res && tx_line, "frame end not idle")
	`UST_ASSERT_NEXT(a_queue_drains, pop_valid && pop_ready, out_valid, "popped op left no result")

endmodule

@@ tb/sv/uart_serial_transmitter_tb.sv @@
// self-checking testbench for the serial transmitter: register port, beats in, line states out
module uart_serial_transmitter_tb
	import ust_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 2_000_000;
	localparam int SettleCycles = 8;

	// line state and flags after one beat
	typedef struct packed {
		logic tx_line;
		logic busy;
		logic rejected;
		logic frame_done;
	} line_state_t;

	localparam line_state_t LineIdle   = '{1'b1, 1'b0, 1'b0, 1'b0};
	localparam line_state_t FrameStart = '{1'b0, 1'b1, 1'b0, 1'b0};
	localparam line_state_t RejectLow  = '{1'b0, 1'b1, 1'b1, 1'b0};
	localparam line_state_t FrameEnd   = '{1'b1, 1'b0, 1'b0, 1'b1};
	localparam line_state_t NoCheck    = '0;

	typedef struct {
		op_kind_t    kind;
		logic [7:0]  data;
		bit          typed;
		line_state_t want;
	} stim_row_t;

	typedef struct {
		logic [15:0] period;
		logic [3:0]  dbits;
		logic        par_en;
		logic        par_odd;
		logic [1:0]  stops;
		int          items;
		int          send_idle;
		int          recv_stall;
	} frame_setup_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        command = 1'b0;
	logic [7:0]  tx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        tx_line;
	logic        busy_res;
	logic        rejected;
	logic        frame_done;

	// register copies, at reset values
	logic [15:0] bit_period_r  = BitPeriodRst;
	logic [3:0]  word_len_r    = DataBitsRst;
	logic        par_en_r      = ParityEnableRst;
	logic        par_odd_r     = ParityOddRst;
	logic [1:0]  stop_count_r  = StopCountRst;

	// frame state of the line model
	phase_t      frame_ph = PH_IDLE;
	logic [15:0] tick_cnt = '0;
	logic [3:0]  bit_pos = '0;
	logic [7:0]  shift_q = '0;
	logic        par_acc = 1'b0;
	logic        line_lvl = 1'b1;

	line_state_t line_states_due[$];
	int          mismatch_count = 0;
	int          beats_out = 0;
	int          cycle_count = 0;
	int          sender_idle_pct = 0;
	int          receiver_stall_pct = 0;

	// idle tick, a frame of all ones with a rejected request on the start bit,
	// then a frame of zeros with a rejected request in the data bits
	stim_row_t directed_rows [27] = '{
		'{OP_TICK, 8'h00, 1'b1, LineIdle},
		'{OP_SEND, 8'hFF, 1'b1, FrameStart},
		'{OP_SEND, 8'h00, 1'b1, RejectLow},
		'{OP_TICK, 8'hFF, 1'b0, NoCheck},
		'{OP_TICK, 8'h00, 1'b0, NoCheck},
		'{OP_TICK, 8'hFF, 1'b0, NoCheck},
		'{OP_TICK, 8'h00, 1'b0, NoCheck},
		'{OP_TICK, 8'hFF, 1'b0, NoCheck},
		'{OP_TICK, 8'h00, 1'b0, NoCheck},
		'{OP_TICK, 8'hFF, 1'b0, NoCheck},
		'{OP_TICK, 8'h00, 1'b0, NoCheck},
		'{OP_TICK, 8'hFF, 1'b0, NoCheck},
		'{OP_TICK, 8'h00, 1'b0, NoCheck},
		'{OP_TICK, 8'h00, 1'b1, FrameEnd},
		'{OP_SEND, 8'h00, 1'b1, FrameStart},
		'{OP_TICK, 8'hFF, 1'b0, NoCheck},
		'{OP_TICK, 8'h00, 1'b0, NoCheck},
		'{OP_TICK, 8'hFF, 1'b0, NoCheck},
		'{OP_TICK, 8'h00, 1'b0, NoCheck},
		'{OP_SEND, 8'hA5, 1'b1, RejectLow},
		'{OP_TICK, 8'hFF, 1'b0, NoCheck},
		'{OP_TICK, 8'h00, 1'b0, NoCheck},
		'{OP_TICK, 8'hFF, 1'b0, NoCheck},
		'{OP_TICK, 8'h00, 1'b0, NoCheck},
		'{OP_TICK, 8'hFF, 1'b0, NoCheck},
		'{OP_TICK, 8'h00, 1'b0, NoCheck},
		'{OP_TICK, 8'h00, 1'b1, FrameEnd}
	};

	// frame formats per phase; the last one sends a single frame at a slower rate
	frame_setup_t setups [8] = '{
		'{16'd1,     4'd8,  1'b1, 1'b0, 2'd1, 80, 33, 63},
		'{16'd0,     4'd5,  1'b1, 1'b1, 2'd2, 80, 33, 63},
		'{16'd3,     4'd15, 1'b0, 1'b1, 2'd3, 70, 33, 63},
		'{16'd2,     4'd6,  1'b1, 1'b1, 2'd0, 80, 63, 33},
		'{16'd4,     4'd0,  1'b1, 1'b0, 2'd2, 70, 63, 33},
		'{16'd1,     4'd7,  1'b0, 1'b0, 2'd1, 80, 63, 33},
		'{16'd2,     4'd9,  1'b1, 1'b1, 2'd2, 60, 0,  0},
		'{16'd12,    4'd4,  1'b0, 1'b1, 2'd0, 0,  0,  0}
	};

	uart_serial_transmitter dut (.*);

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		$display("ERROR %0t ns: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic logic [3:0] clamped_word_len();
		if (word_len_r < DataBitsMin) return DataBitsMin;
		if (word_len_r > DataBitsMax) return DataBitsMax;
		return word_len_r;
	endfunction

	function automatic logic [3:0] clamped_stops();
		if (stop_count_r < StopMin) return {2'b00, StopMin};
		if (stop_count_r > StopMax) return {2'b00, StopMax};
		return {2'b00, stop_count_r};
	endfunction

	// moves to the next bit of the frame, returns 1 when the last stop bit ends
	function automatic logic advance_bit();
		case (frame_ph)
			PH_START: begin
				frame_ph = PH_DATA;
				bit_pos = '0;
				line_lvl = shift_q[0];
				par_acc ^= shift_q[0];
			end
			PH_DATA: begin
				bit_pos = bit_pos + 4'd1;
				shift_q = shift_q >> 1;
				if (bit_pos >= clamped_word_len()) begin
					if (par_en_r) begin
						frame_ph = PH_PARITY;
						line_lvl = par_acc ^ par_odd_r;
					end else begin
						frame_ph = PH_STOP;
						bit_pos = '0;
						line_lvl = 1'b1;
					end
				end else begin
					line_lvl = shift_q[0];
					par_acc ^= shift_q[0];
				end
			end
			PH_PARITY: begin
				frame_ph = PH_STOP;
				bit_pos = '0;
				line_lvl = 1'b1;
			end
			PH_STOP: begin
				bit_pos = bit_pos + 4'd1;
				if (bit_pos >= clamped_stops()) begin
					frame_ph = PH_IDLE;
					bit_pos = '0;
					line_lvl = 1'b1;
					return 1'b1;
				end
			end
			default: begin
				frame_ph = PH_IDLE;
				line_lvl = 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	// line state after one tick or send request
	function automatic line_state_t serial_frame_step(op_kind_t kind, logic [7:0] data);
		line_state_t st;
		logic [16:0] next_cnt;
		logic [15:0] period;
		st = '0;
		if (kind == OP_SEND) begin
			if (frame_ph == PH_IDLE) begin
				shift_q = data;
				frame_ph = PH_START;
				tick_cnt = '0;
				bit_pos = '0;
				par_acc = 1'b0;
				line_lvl = 1'b0;
			end else begin
				st.rejected = 1'b1;
			end
		end else if (frame_ph != PH_IDLE) begin
			// a zero period counts as one
			period = (bit_period_r == '0) ? 16'd1 : bit_period_r;
			next_cnt = {1'b0, tick_cnt} + 17'd1;
			if (next_cnt >= {1'b0, period}) begin
				tick_cnt = '0;
				st.frame_done = advance_bit();
			end else begin
				tick_cnt = next_cnt[15:0];
			end
		end else begin
			line_lvl = 1'b1;
		end
		st.tx_line = line_lvl;
		st.busy = (frame_ph != PH_IDLE);
		return st;
	endfunction

	// register access: optional write, then a read back of the same register
	task automatic reg_access(logic [RegIdxW-1:0] idx, bit do_write, logic [31:0] wdata);
		logic [31:0] reg_value;
		@(posedge clk);
		if (do_write) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {idx, 2'b00};
			pwdata <= wdata;
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			case (idx)
				REG_BIT_PERIOD:    bit_period_r = wdata[15:0];
				REG_WORD_LEN:      word_len_r = wdata[3:0];
				REG_PARITY_ENABLE: par_en_r = wdata[0];
				REG_PARITY_ODD:    par_odd_r = wdata[0];
				REG_STOP_COUNT:    stop_count_r = wdata[1:0];
				default: ;
			endcase
			penable <= 1'b0;
		end else begin
			psel <= 1'b1;
			penable <= 1'b0;
		end
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_BIT_PERIOD:    reg_value = {16'b0, bit_period_r};
			REG_WORD_LEN:      reg_value = {28'b0, word_len_r};
			REG_PARITY_ENABLE: reg_value = {31'b0, par_en_r};
			REG_PARITY_ODD:    reg_value = {31'b0, par_odd_r};
			REG_STOP_COUNT:    reg_value = {30'b0, stop_count_r};
			default:           reg_value = '0;
		endcase
		if (prdata !== reg_value)
			report_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata, reg_value));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// one input beat, with a random gap before it
	task automatic drive_beat(op_kind_t kind, logic [7:0] data, bit typed, line_state_t want);
		line_state_t predicted;
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		command <= kind;
		tx_byte <= data;
		do @(posedge clk); while (!in_ready);
		predicted = serial_frame_step(kind, data);
		line_states_due.push_back(typed ? want : predicted);
	endtask

	// tick out any running frame, then wait for every line state
	task automatic finish_frame_and_drain();
		while (frame_ph != PH_IDLE)
			drive_beat(OP_TICK, 8'($urandom_range(0, 255)), 1'b0, NoCheck);
		in_valid <= 1'b0;
		while (line_states_due.size() != 0)
			@(posedge clk);
	endtask

	// result side stalls
	initial begin
		forever begin
			@(posedge clk);
			out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	// compare each result beat with the oldest predicted line state
	always @(posedge clk) begin
		line_state_t got;
		line_state_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{tx_line, busy_res, rejected, frame_done};
			if (line_states_due.size() == 0) begin
				report_mismatch($sformatf("beat %0d: result with nothing pending", beats_out));
			end else begin
				want = line_states_due.pop_front();
				if (got.tx_line !== want.tx_line)
					report_mismatch($sformatf("beat %0d: tx_line %b, want %b",
						beats_out, got.tx_line, want.tx_line));
				if (got.busy !== want.busy)
					report_mismatch($sformatf("beat %0d: busy_res %b, want %b",
						beats_out, got.busy, want.busy));
				if (got.rejected !== want.rejected)
					report_mismatch($sformatf("beat %0d: rejected %b, want %b",
						beats_out, got.rejected, want.rejected));
				if (got.frame_done !== want.frame_done)
					report_mismatch($sformatf("beat %0d: frame_done %b, want %b",
						beats_out, got.frame_done, want.frame_done));
			end
			beats_out++;
		end
	end

	// stimulus
	initial begin
		frame_setup_t fs;
		op_kind_t     kind;
		logic [7:0]   data;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset values
		reg_access(REG_BIT_PERIOD, 1'b0, '0);
		reg_access(REG_WORD_LEN, 1'b0, '0);
		reg_access(REG_PARITY_ENABLE, 1'b0, '0);
		reg_access(REG_PARITY_ODD, 1'b0, '0);
		reg_access(REG_STOP_COUNT, 1'b0, '0);

		// directed frames at one tick per bit, default 8E1 format
		reg_access(REG_BIT_PERIOD, 1'b1, 32'd1);
		sender_idle_pct = 33;
		receiver_stall_pct = 63;
		foreach (directed_rows[r])
			drive_beat(directed_rows[r].kind, directed_rows[r].data,
				directed_rows[r].typed, directed_rows[r].want);
		finish_frame_and_drain();

		// random traffic, one frame format per phase
		foreach (setups[p]) begin
			fs = setups[p];
			sender_idle_pct = fs.send_idle;
			receiver_stall_pct = fs.recv_stall;
			// upper bits of each write are noise the register drops
			reg_access(REG_BIT_PERIOD, 1'b1, ($urandom() & 32'hFFFF_0000) | fs.period);
			reg_access(REG_WORD_LEN, 1'b1, ($urandom() & 32'hFFFF_FFF0) | fs.dbits);
			reg_access(REG_PARITY_ENABLE, 1'b1, ($urandom() & 32'hFFFF_FFFE) | fs.par_en);
			reg_access(REG_PARITY_ODD, 1'b1, ($urandom() & 32'hFFFF_FFFE) | fs.par_odd);
			reg_access(REG_STOP_COUNT, 1'b1, ($urandom() & 32'hFFFF_FFFC) | fs.stops);
			if (fs.items == 0) begin
				// a single slow frame with a rejected request on its start bit
				drive_beat(OP_SEND, 8'($urandom_range(0, 255)), 1'b0, NoCheck);
				drive_beat(OP_SEND, 8'($urandom_range(0, 255)), 1'b0, NoCheck);
			end
			for (int i = 0; i < fs.items; i++) begin
				// mostly ticks; requests often when idle, now and then while busy
				if (frame_ph == PH_IDLE)
					kind = ($urandom_range(0, 99) < 35) ? OP_SEND : OP_TICK;
				else
					kind = ($urandom_range(0, 99) < 6) ? OP_SEND : OP_TICK;
				case ($urandom_range(0, 7))
					0: data = 8'h00;
					1: data = 8'hFF;
					default: data = 8'($urandom_range(0, 255));
				endcase
				drive_beat(kind, data, 1'b0, NoCheck);
			end
			finish_frame_and_drain();
		end

		repeat (SettleCycles) @(posedge clk);
		if (mismatch_count == 0 && line_states_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ust_pkg.sv
rtl/ust_front.sv
rtl/ust_queue.sv
rtl/ust_engine.sv
rtl/uart_serial_transmitter.sv
tb/sv/uart_serial_transmitter_tb.sv
